// ----- rtl/sqc_pkg.sv -----
// sqc_pkg: widths, register indexes, lane and quad types for the sprite clipper
// used by every module and interface of the block; no dependencies
package sqc_pkg;

  localparam int COORD_W = 16;
  localparam int CLIP_W = 12;
  localparam int UV_W = 18;
  localparam int COL_W = 32;
  localparam int TEX_W = 8;
  localparam int SPAN_W = 17;
  localparam int PROD_W = UV_W + SPAN_W;
  localparam int NUM_W = PROD_W + 2;
  localparam int DEN_W = SPAN_W + 1;
  localparam int DIV_BITS = UV_W;
  localparam int LERP_DEPTH = DIV_BITS + 3;
  localparam int LANES = 4;
  localparam int VERTS = 6;
  localparam int VCNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = CLIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_ENABLE = 3'd0,
    REG_CLIP_LEFT   = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LANE_LEFT   = 2'd0,
    LANE_RIGHT  = 2'd1,
    LANE_TOP    = 2'd2,
    LANE_BOTTOM = 2'd3
  } lane_t;

  typedef struct packed {
    logic                    enable;
    logic signed [CLIP_W-1:0] left;
    logic signed [CLIP_W-1:0] top;
    logic signed [CLIP_W-1:0] right;
    logic signed [CLIP_W-1:0] bottom;
  } clip_cfg_t;

  typedef struct packed {
    logic [UV_W-1:0]   a;
    logic              neg;
    logic [UV_W-1:0]   mag;
    logic [SPAN_W-1:0] n;
    logic [SPAN_W-1:0] d;
  } lerp_in_t;

  typedef struct packed {
    logic                      reject;
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
    logic [COL_W-1:0]          rgba;
    logic [TEX_W-1:0]          tex;
  } side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
    logic [UV_W-1:0]           ul;
    logic [UV_W-1:0]           ut;
    logic [UV_W-1:0]           ur;
    logic [UV_W-1:0]           ub;
    logic [COL_W-1:0]          rgba;
    logic [TEX_W-1:0]          tex;
  } quad_t;

  function automatic lerp_in_t make_lane(logic [UV_W-1:0] a, logic [UV_W-1:0] b,
                                         logic act, logic signed [SPAN_W:0] n,
                                         logic signed [SPAN_W:0] d);
    logic signed [UV_W:0] diff;
    lerp_in_t             o;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    o.a = a;
    o.neg = diff[UV_W];
    o.mag = diff[UV_W] ? UV_W'(-diff) : UV_W'(diff);
    o.n = SPAN_W'(n);
    o.d = SPAN_W'(d);
    if (!act) begin
      o.mag = '0;
      o.n = '0;
      o.d = SPAN_W'(1);
    end
    return o;
  endfunction

endpackage

// ----- rtl/sqc_sprite_if.sv -----
// sqc_sprite_if, sqc_vertex_if: valid/ready channels for sprites and vertices
// depends on sqc_pkg
interface sqc_sprite_if;
  import sqc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] dst_left;
  logic signed [COORD_W-1:0] dst_top;
  logic signed [COORD_W-1:0] dst_right;
  logic signed [COORD_W-1:0] dst_bottom;
  logic [UV_W-1:0]           uv_left;
  logic [UV_W-1:0]           uv_top;
  logic [UV_W-1:0]           uv_right;
  logic [UV_W-1:0]           uv_bottom;
  logic [COL_W-1:0]          rgba;
  logic [TEX_W-1:0]          tex_id;
  modport source (output valid, dst_left, dst_top, dst_right, dst_bottom,
                  uv_left, uv_top, uv_right, uv_bottom, rgba, tex_id, input ready);
  modport sink (input valid, dst_left, dst_top, dst_right, dst_bottom,
                uv_left, uv_top, uv_right, uv_bottom, rgba, tex_id, output ready);
endinterface

interface sqc_vertex_if;
  import sqc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vx;
  logic signed [COORD_W-1:0] vy;
  logic [UV_W-1:0]           vu;
  logic [UV_W-1:0]           vv;
  logic [COL_W-1:0]          vcolor;
  logic [TEX_W-1:0]          vtex;
  logic                      last_vertex;
  modport source (output valid, vx, vy, vu, vv, vcolor, vtex, last_vertex, input ready);
  modport sink (input valid, vx, vy, vu, vv, vcolor, vtex, last_vertex, output ready);
endinterface

// ----- rtl/sqc_setup.sv -----
// sqc_setup: rejection test, clipped edges and lerp lane operands, one register stage
// depends on sqc_pkg
module sqc_setup
  import sqc_pkg::*;
(
  input  logic                      clk,
  input  logic                      adv,
  input  clip_cfg_t                 cfg,
  input  logic signed [COORD_W-1:0] l,
  input  logic signed [COORD_W-1:0] t,
  input  logic signed [COORD_W-1:0] r,
  input  logic signed [COORD_W-1:0] b,
  input  logic [UV_W-1:0]           ul,
  input  logic [UV_W-1:0]           ut,
  input  logic [UV_W-1:0]           ur,
  input  logic [UV_W-1:0]           ub,
  input  logic [COL_W-1:0]          rgba,
  input  logic [TEX_W-1:0]          tex,
  output lerp_in_t                  lane [LANES],
  output side_t                     side
);

  logic signed [COORD_W-1:0] cl, ct, cr, cb;
  logic signed [SPAN_W:0]    dx, dy, n_l, n_r, n_t, n_b;
  logic                      reject, act_l, act_r, act_t, act_b;
  lerp_in_t                  lane_next [LANES];
  side_t                     side_next;

  always_comb begin
    cl = {cfg.left, 4'b0};
    ct = {cfg.top, 4'b0};
    cr = {cfg.right, 4'b0};
    cb = {cfg.bottom, 4'b0};
    reject = cfg.enable && (l >= cr || r < cl || t >= cb || b < ct);
    act_l = cfg.enable && !reject && l < cl;
    act_r = cfg.enable && !reject && r > cr;
    act_t = cfg.enable && !reject && t < ct;
    act_b = cfg.enable && !reject && b > cb;
    dx = (SPAN_W+1)'(r) - (SPAN_W+1)'(l);
    dy = (SPAN_W+1)'(b) - (SPAN_W+1)'(t);
    n_l = (SPAN_W+1)'(cl) - (SPAN_W+1)'(l);
    n_r = (SPAN_W+1)'(r) - (SPAN_W+1)'(cr);
    n_t = (SPAN_W+1)'(ct) - (SPAN_W+1)'(t);
    n_b = (SPAN_W+1)'(b) - (SPAN_W+1)'(cb);
    lane_next[LANE_LEFT]   = make_lane(ul, ur, act_l, n_l, dx);
    lane_next[LANE_RIGHT]  = make_lane(ur, ul, act_r, n_r, dx);
    lane_next[LANE_TOP]    = make_lane(ub, ut, act_t, n_t, dy);
    lane_next[LANE_BOTTOM] = make_lane(ut, ub, act_b, n_b, dy);
    side_next.reject = reject;
    side_next.l = act_l ? cl : l;
    side_next.r = act_r ? cr : r;
    side_next.t = act_t ? ct : t;
    side_next.b = act_b ? cb : b;
    side_next.rgba = rgba;
    side_next.tex = tex;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane <= lane_next;
      side <= side_next;
    end
  end

endmodule

// ----- rtl/sqc_lerp.sv -----
// sqc_lerp: a + (b-a)*n/d rounded to nearest; multiply, bias, one quotient bit per stage
// depends on sqc_pkg
module sqc_lerp
  import sqc_pkg::*;
(
  input  logic            clk,
  input  logic            adv,
  input  lerp_in_t        op,
  output logic [UV_W-1:0] res
);

  logic [PROD_W-1:0]   prod;
  logic [SPAN_W-1:0]   d_p;
  logic [UV_W-1:0]     a_s [DIV_BITS+2];
  logic                neg_s [DIV_BITS+2];
  logic [NUM_W-1:0]    rem_s [DIV_BITS+1];
  logic [DEN_W-1:0]    den_s [DIV_BITS+1];
  logic [DIV_BITS-1:0] q_s [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= PROD_W'(op.mag * op.n);
      d_p <= op.d;
      a_s[0] <= op.a;
      neg_s[0] <= op.neg;
      rem_s[0] <= {prod, 1'b0} + NUM_W'(d_p);
      den_s[0] <= {d_p, 1'b0};
      q_s[0] <= '0;
      a_s[1] <= a_s[0];
      neg_s[1] <= neg_s[0];
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
    logic [NUM_W-1:0] dsh;
    assign dsh = NUM_W'(den_s[k-1]) << (DIV_BITS - k);
    always_ff @(posedge clk) begin
      if (adv) begin
        den_s[k] <= den_s[k-1];
        a_s[k+1] <= a_s[k];
        neg_s[k+1] <= neg_s[k];
        if (rem_s[k-1] >= dsh) begin
          rem_s[k] <= rem_s[k-1] - dsh;
          q_s[k] <= q_s[k-1] | (DIV_BITS'(1) << (DIV_BITS - k));
        end else begin
          rem_s[k] <= rem_s[k-1];
          q_s[k] <= q_s[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= neg_s[DIV_BITS+1] ? a_s[DIV_BITS+1] - q_s[DIV_BITS]
                               : a_s[DIV_BITS+1] + q_s[DIV_BITS];
    end
  end

endmodule

// ----- rtl/sqc_emit.sv -----
// sqc_emit: holds one clipped quad and sends its six vertices as two triangles
// depends on sqc_pkg and sqc_vertex_if
module sqc_emit
  import sqc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  tail_valid,
  input  quad_t tail,
  output logic  take,
  sqc_vertex_if.source vertex
);

  logic              busy;
  logic [VCNT_W-1:0] cnt;
  quad_t             q;
  logic              is_last, use_r, use_b;

  assign is_last = cnt == VCNT_W'(VERTS - 1);
  assign take = !busy || (vertex.ready && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (take) begin
      busy <= tail_valid;
      cnt <= '0;
    end else if (vertex.ready) begin
      cnt <= cnt + VCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q <= tail;
    end
  end

  always_comb begin
    use_r = cnt inside {3'd1, 3'd2, 3'd4};
    use_b = cnt inside {3'd2, 3'd4, 3'd5};
  end

  assign vertex.valid = busy;
  assign vertex.vx = use_r ? q.r : q.l;
  assign vertex.vy = use_b ? q.b : q.t;
  assign vertex.vu = use_r ? q.ur : q.ul;
  assign vertex.vv = use_b ? q.ut : q.ub;
  assign vertex.vcolor = q.rgba;
  assign vertex.vtex = q.tex;
  assign vertex.last_vertex = is_last;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && !vertex.ready |=> vertex.valid && $stable(cnt))
    else $error("vertex dropped while stalled");
  a_step: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && vertex.ready && !vertex.last_vertex |=> cnt == $past(cnt) + VCNT_W'(1))
    else $error("vertex counter skipped");
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |-> !busy || (vertex.last_vertex && vertex.ready))
    else $error("quad replaced before last vertex");

endmodule

// ----- rtl/sprite_quad_clip_and_vertex_emit.sv -----
// sprite_quad_clip_and_vertex_emit: clip registers, 22-stage clip/lerp pipeline, vertex emitter
// past the pipeline and emitter register, vertices leave one a cycle while vertex.ready is high
// the single vertex channel at six vertices a sprite sets the rate; rejected sprites cost none
// the pipeline takes a sprite every cycle while its tail is free or leaving, and stalls as a whole
// reset (rst, synchronous, active high) empties pipeline and emitter and loads default clip box
module sprite_quad_clip_and_vertex_emit
  import sqc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sqc_sprite_if.sink            sprite,
  sqc_vertex_if.source          vertex
);

  clip_cfg_t       cfg;
  logic            adv, take;
  logic            v [LERP_DEPTH+1];
  side_t           sd [LERP_DEPTH+1];
  lerp_in_t        lane [LANES];
  logic [UV_W-1:0] res [LANES];
  quad_t           tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.left <= '0;
      cfg.top <= '0;
      cfg.right <= CLIP_W'(2047);
      cfg.bottom <= CLIP_W'(2047);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIP_ENABLE: cfg.enable <= cfg_data[0];
        REG_CLIP_LEFT:   cfg.left <= cfg_data;
        REG_CLIP_TOP:    cfg.top <= cfg_data;
        REG_CLIP_RIGHT:  cfg.right <= cfg_data;
        REG_CLIP_BOTTOM: cfg.bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // a rejected sprite at the tail leaves without waiting for the emitter
  assign adv = !v[LERP_DEPTH] || sd[LERP_DEPTH].reject || take;
  assign sprite.ready = adv;

  sqc_setup u_setup (
    .clk  (clk),
    .adv  (adv),
    .cfg  (cfg),
    .l    (sprite.dst_left),
    .t    (sprite.dst_top),
    .r    (sprite.dst_right),
    .b    (sprite.dst_bottom),
    .ul   (sprite.uv_left),
    .ut   (sprite.uv_top),
    .ur   (sprite.uv_right),
    .ub   (sprite.uv_bottom),
    .rgba (sprite.rgba),
    .tex  (sprite.tex_id),
    .lane (lane),
    .side (sd[0])
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sqc_lerp u_lerp (
      .clk (clk),
      .adv (adv),
      .op  (lane[i]),
      .res (res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LERP_DEPTH; i++) v[i] <= 1'b0;
    end else if (adv) begin
      v[0] <= sprite.valid;
      for (int i = 1; i <= LERP_DEPTH; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= LERP_DEPTH; i++) sd[i] <= sd[i-1];
    end
  end

  always_comb begin
    tail.l = sd[LERP_DEPTH].l;
    tail.t = sd[LERP_DEPTH].t;
    tail.r = sd[LERP_DEPTH].r;
    tail.b = sd[LERP_DEPTH].b;
    tail.ul = res[LANE_LEFT];
    tail.ur = res[LANE_RIGHT];
    tail.ub = res[LANE_TOP];
    tail.ut = res[LANE_BOTTOM];
    tail.rgba = sd[LERP_DEPTH].rgba;
    tail.tex = sd[LERP_DEPTH].tex;
  end

  sqc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (v[LERP_DEPTH] && !sd[LERP_DEPTH].reject),
    .tail       (tail),
    .take       (take),
    .vertex     (vertex)
  );

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> v[LERP_DEPTH] && $stable(sd[LERP_DEPTH]))
    else $error("pipeline tail lost during stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !sprite.ready |-> v[LERP_DEPTH] && vertex.valid)
    else $error("input stalled without a full pipeline");
  a_rej: assert property (@(posedge clk) disable iff (rst)
    v[LERP_DEPTH] && sd[LERP_DEPTH].reject && take |=> !vertex.valid)
    else $error("rejected sprite produced vertices");

endmodule

// ----- bench/tb_sprite_quad_clip_and_vertex_emit.sv -----
// tb_sprite_quad_clip_and_vertex_emit: drives sprites and clip settings into the clipper,
// predicts the six vertices of each sprite that is not culled and checks them in order
// depends on sqc_pkg, sqc_sprite_if, sqc_vertex_if and the block itself
`timescale 1ns / 1ps

module tb_sprite_quad_clip_and_vertex_emit;
  import sqc_pkg::*;

  typedef struct {
    logic signed [15:0] x, y;
    logic [17:0] u, v;
    logic [31:0] col;
    logic [7:0] tex;
    logic last;
  } vert_t;

  class vertex_scoreboard;
    vert_t pending[$];
    int errors;
    int sprites;
    int verts;
    int culled;
    bit en;
    int cl, ct, cr, cb;

    function void set_reg(cfg_reg_t idx, logic [11:0] val);
      case (idx)
        REG_CLIP_ENABLE: en = val[0];
        REG_CLIP_LEFT: cl = $signed(val);
        REG_CLIP_TOP: ct = $signed(val);
        REG_CLIP_RIGHT: cr = $signed(val);
        REG_CLIP_BOTTOM: cb = $signed(val);
        default: ;
      endcase
    endfunction

    function longint interp(longint a, longint b, longint n, longint d);
      longint diff, mag, q;
      diff = b - a;
      mag = diff < 0 ? -diff : diff;
      if (d <= 0 || n <= 0) return a;
      q = (mag * n * 2 + d) / (d * 2);
      return diff < 0 ? a - q : a + q;
    endfunction

    function void note_sprite(quad_t s);
      longint l, t, r, b, ul, ut, ur, ub, nul, nut, nur, nub;
      longint xs[6], ys[6], us[6], vs[6];
      longint c_l, c_t, c_r, c_b;
      vert_t vt;
      l = s.l; t = s.t; r = s.r; b = s.b;
      ul = s.ul; ut = s.ut; ur = s.ur; ub = s.ub;
      sprites++;
      if (en) begin
        c_l = cl * 16; c_t = ct * 16; c_r = cr * 16; c_b = cb * 16;
        if (l >= c_r || r < c_l || t >= c_b || b < c_t) begin
          culled++;
          return;
        end
        nul = ul; nut = ut; nur = ur; nub = ub;
        if (l < c_l) nul = interp(ul, ur, c_l - l, r - l);
        if (r > c_r) nur = interp(ur, ul, r - c_r, r - l);
        if (t < c_t) nub = interp(ub, ut, c_t - t, b - t);
        if (b > c_b) nut = interp(ut, ub, b - c_b, b - t);
        if (l < c_l) l = c_l;
        if (r > c_r) r = c_r;
        if (t < c_t) t = c_t;
        if (b > c_b) b = c_b;
        ul = nul; ut = nut; ur = nur; ub = nub;
      end
      xs = '{l, r, r, l, r, l};
      ys = '{t, t, b, t, b, b};
      us = '{ul, ur, ur, ul, ur, ul};
      vs = '{ub, ub, ut, ub, ut, ut};
      for (int k = 0; k < 6; k++) begin
        vt.x = xs[k][15:0]; vt.y = ys[k][15:0];
        vt.u = us[k][17:0]; vt.v = vs[k][17:0];
        vt.col = s.rgba; vt.tex = s.tex; vt.last = (k == 5);
        pending.push_back(vt);
      end
    endfunction

    function void check_vertex(vert_t got);
      vert_t e;
      verts++;
      if (pending.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin $error("vx exp %0d got %0d", e.x, got.x); errors++; end
      if (got.y !== e.y) begin $error("vy exp %0d got %0d", e.y, got.y); errors++; end
      if (got.u !== e.u) begin $error("vu exp %0h got %0h", e.u, got.u); errors++; end
      if (got.v !== e.v) begin $error("vv exp %0h got %0h", e.v, got.v); errors++; end
      if (got.col !== e.col) begin
        $error("vcolor exp %0h got %0h", e.col, got.col); errors++;
      end
      if (got.tex !== e.tex) begin $error("vtex exp %0h got %0h", e.tex, got.tex); errors++; end
      if (got.last !== e.last) begin
        $error("last_vertex exp %0b got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  longint cycles = 0;
  localparam longint LIMIT = 400000;

  sqc_sprite_if sprite();
  sqc_vertex_if vertex();

  sprite_quad_clip_and_vertex_emit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sprite(sprite.sink), .vertex(vertex.source)
  );

  vertex_scoreboard sb = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    sprite.valid = 0;
    sprite.dst_left = 0; sprite.dst_top = 0; sprite.dst_right = 0; sprite.dst_bottom = 0;
    sprite.uv_left = 0; sprite.uv_top = 0; sprite.uv_right = 0; sprite.uv_bottom = 0;
    sprite.rgba = 0; sprite.tex_id = 0;
    vertex.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off counted here
  always @(posedge clk) begin
    if (!rst && vertex.valid && vertex.ready) begin
      vert_t g;
      g.x = vertex.vx; g.y = vertex.vy; g.u = vertex.vu; g.v = vertex.vv;
      g.col = vertex.vcolor; g.tex = vertex.vtex; g.last = vertex.last_vertex;
      sb.check_vertex(g);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      vertex.ready <= 0;
    end else begin
      vertex.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_clip(bit en, int l, int t, int r, int b);
    write_reg(REG_CLIP_ENABLE, {11'd0, en});
    write_reg(REG_CLIP_LEFT, 12'(l));
    write_reg(REG_CLIP_TOP, 12'(t));
    write_reg(REG_CLIP_RIGHT, 12'(r));
    write_reg(REG_CLIP_BOTTOM, 12'(b));
  endtask

  task automatic send_sprite(quad_t s);
    while ($urandom_range(99) < send_idle) begin
      sprite.valid <= 0;
      @(posedge clk);
    end
    sprite.valid <= 1;
    sprite.dst_left <= s.l; sprite.dst_top <= s.t;
    sprite.dst_right <= s.r; sprite.dst_bottom <= s.b;
    sprite.uv_left <= s.ul; sprite.uv_top <= s.ut;
    sprite.uv_right <= s.ur; sprite.uv_bottom <= s.ub;
    sprite.rgba <= s.rgba; sprite.tex_id <= s.tex;
    do @(posedge clk); while (!sprite.ready);
    sb.note_sprite(s);
  endtask

  task automatic drain();
    sprite.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic quad_t make_quad(int l, int t, int r, int b);
    quad_t q;
    q.l = 16'(l); q.t = 16'(t); q.r = 16'(r); q.b = 16'(b);
    q.ul = 18'($urandom); q.ut = 18'($urandom); q.ur = 18'($urandom); q.ub = 18'($urandom);
    q.rgba = $urandom; q.tex = 8'($urandom);
    return q;
  endfunction

  // mostly sprites straddling the clip box, some raw noise
  function automatic quad_t rand_quad(int cl, int ct, int cr, int cb);
    quad_t q;
    int l, t, w, h;
    if ($urandom_range(9) < 2) return make_quad($urandom, $urandom, $urandom, $urandom);
    l = cl * 16 + $signed($urandom_range(2000)) - 1000;
    t = ct * 16 + $signed($urandom_range(2000)) - 1000;
    w = $urandom_range(1, 3000);
    h = $urandom_range(1, 3000);
    if ($urandom_range(9) == 0) w = (cr - cl) * 16 + $urandom_range(40);
    q = make_quad(l, t, l + w, t + h);
    if (l + w > 32767) q.r = 16'sd32767;
    if (t + h > 32767) q.b = 16'sd32767;
    return q;
  endfunction

  initial begin
    quad_t q;
    int cl, ct, cr, cb;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: extremes, edges on each side, rejects
    q = make_quad(-32768, -32768, 32767, 32767);
    q.ul = 0; q.ut = 18'h3ffff; q.ur = 18'h3ffff; q.ub = 0;
    q.rgba = 32'hffffffff; q.tex = 8'hff;
    send_sprite(q);
    send_sprite(make_quad(100, 200, 50, 20));
    drain();
    set_clip(1, 0, 0, 2047, 2047);
    send_sprite(q);
    send_sprite(make_quad(-160, 16, 160, 320));
    send_sprite(make_quad(16, -160, 320, 160));
    send_sprite(make_quad(32752, 16, 32767, 32));
    send_sprite(make_quad(-100, 16, -1, 32));
    send_sprite(make_quad(0, 0, 0, 0));
    send_sprite(make_quad(16, 16, 10, 10));
    drain();
    set_clip(1, -2048, -2048, 2047, 2047);
    send_sprite(q);
    drain();
    set_clip(1, 10, 10, 20, 20);
    send_sprite(make_quad(0, 0, 400, 400));
    send_sprite(make_quad(160, 160, 320, 320));
    send_sprite(make_quad(159, 159, 321, 321));
    send_sprite(make_quad(320, 150, 400, 200));
    send_sprite(make_quad(150, 320, 200, 400));
    send_sprite(make_quad(150, 100, 200, 159));
    drain();
    set_clip(1, 20, 20, 10, 10);
    send_sprite(make_quad(0, 0, 400, 400));
    drain();
    write_reg(cfg_reg_t'(3'd7), 12'hfff);

    // pressure: receiver held off while sprites keep coming
    hold_off <= 300;
    for (int i = 0; i < 15; i++) send_sprite(make_quad(0, 0, 400, 400));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 51; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 51; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      cl = $signed($urandom_range(4095)) - 2048;
      ct = $signed($urandom_range(4095)) - 2048;
      cr = cl + $urandom_range(1, 400);
      cb = ct + $urandom_range(1, 400);
      if (cr > 2047) cr = 2047;
      if (cb > 2047) cb = 2047;
      if (ph == 3) begin cl = -2048; ct = -2048; cr = 2047; cb = 2047; end
      if (ph == 5) begin cl = 2047; ct = 2047; cr = -2048; cb = -2048; end
      set_clip(ph != 6, cl, ct, cr, cb);
      for (int i = 0; i < 55; i++) send_sprite(rand_quad(cl, ct, cr, cb));
      drain();
    end

    $display("tb: %0d sprites sent, %0d culled, %0d vertices checked over 8 clip phases",
             sb.sprites, sb.culled, sb.verts);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
